>>> rtl/core/dtqom_pkg.sv
// Package for the drop-tail queue occupancy monitor.
// Holds the word types, the op and action codes and the controller types.
// Used by every module of the block; depends on nothing.
package dtqom_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int HIST_W = 48;
   localparam int TIME_W = 32;
   localparam int ID_W = 16;
   localparam int LEVEL_W = 5;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [HIST_W-1:0] HIST_MAX = {HIST_W{1'b1}};

   localparam logic [1:0] OP_ARRIVAL = 2'd0;
   localparam logic [1:0] OP_DEPARTURE = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [2:0] ACT_SERVED = 3'd0;
   localparam logic [2:0] ACT_QUEUED = 3'd1;
   localparam logic [2:0] ACT_DROPPED = 3'd2;
   localparam logic [2:0] ACT_STARTED = 3'd3;
   localparam logic [2:0] ACT_IDLE = 3'd4;
   localparam logic [2:0] ACT_READ = 3'd5;

   localparam logic REG_QUEUE_LIMIT = 1'b0;

   typedef struct packed {
      logic [1:0] op;
      logic [ID_W-1:0] packet_id;
      logic [TIME_W-1:0] now_time;
      logic [LEVEL_W-1:0] bin_index;
   } req_word_type;

   typedef struct packed {
      logic [2:0] action;
      logic [ID_W-1:0] affected_packet;
      logic error_flag;
      logic [LEVEL_W-1:0] occupancy;
      logic [HIST_W-1:0] system_bin_time;
      logic [HIST_W-1:0] queue_bin_time;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

>>> rtl/core/dtqom_ctrl.sv
// Controller of the drop-tail queue occupancy monitor.
// Sequences the histogram clearing pass and the accept and execute steps of each word.
// Depends on dtqom_pkg.
module dtqom_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   output dtqom_pkg::cmd_type cmd,
   input  dtqom_pkg::status_type status
);

   dtqom_pkg::state_type state_ff;
   dtqom_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtqom_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = dtqom_pkg::ST_IDLE;
            end
         end
         dtqom_pkg::ST_IDLE: begin
            if (start) begin
               state_in = dtqom_pkg::ST_EXEC;
            end
         end
         dtqom_pkg::ST_EXEC: begin
            state_in = dtqom_pkg::ST_IDLE;
         end
         default: begin
            state_in = dtqom_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtqom_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != dtqom_pkg::ST_IDLE);
   assign cmd.clear = (state_ff == dtqom_pkg::ST_CLEAR);
   assign cmd.accept = (state_ff == dtqom_pkg::ST_IDLE) && start;
   assign cmd.exec = (state_ff == dtqom_pkg::ST_EXEC);

endmodule

>>> rtl/core/dtqom_datapath.sv
// Datapath of the drop-tail queue occupancy monitor.
// Holds the wait store, the histogram memories, queue state, the limit register
// and the result register. Depends on dtqom_pkg.
module dtqom_datapath #(
   parameter int QUEUE_DEPTH = dtqom_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  dtqom_pkg::cmd_type cmd,
   output dtqom_pkg::status_type status,
   input  dtqom_pkg::req_word_type req_word,
   output logic rsp_valid,
   output dtqom_pkg::rsp_word_type rsp_word,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [dtqom_pkg::CSR_AW-1:0] paddr,
   input  logic [dtqom_pkg::CSR_DW-1:0] pwdata,
   output logic [dtqom_pkg::CSR_DW-1:0] prdata
);

   localparam int SYS_DEPTH = QUEUE_DEPTH + 2;
   localparam int Q_DEPTH = QUEUE_DEPTH + 1;
   localparam int SYS_AW = $clog2(SYS_DEPTH);
   localparam int Q_AW = $clog2(Q_DEPTH);
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int HW = dtqom_pkg::HIST_W;
   localparam int TW = dtqom_pkg::TIME_W;
   localparam int IW = dtqom_pkg::ID_W;

   logic [HW-1:0] sys_mem [SYS_DEPTH];
   logic [HW-1:0] q_mem [Q_DEPTH];
   logic [IW-1:0] ws_mem [QUEUE_DEPTH];

   logic [SYS_AW-1:0] clr_ff, clr_in;
   logic [PW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic srv_busy_ff, srv_busy_in;
   logic [IW-1:0] svc_id_ff, svc_id_in;
   logic [TW-1:0] sys_last_ff, sys_last_in;
   logic [TW-1:0] q_last_ff, q_last_in;
   logic [CW-1:0] limit_ff, limit_in;

   logic [1:0] op_ff, op_in;
   logic [IW-1:0] pid_ff, pid_in;
   logic [TW-1:0] now_ff, now_in;
   logic [TW-1:0] sys_delta_ff, sys_delta_in;
   logic [TW-1:0] q_delta_ff, q_delta_in;
   logic sys_ok_ff, sys_ok_in;
   logic q_ok_ff, q_ok_in;
   logic [SYS_AW-1:0] sys_addr_ff, sys_addr_in;
   logic [Q_AW-1:0] q_addr_ff, q_addr_in;

   logic [HW-1:0] sys_rd_ff;
   logic [HW-1:0] q_rd_ff;
   logic [IW-1:0] ws_rd_ff;

   logic rsp_valid_ff;
   dtqom_pkg::rsp_word_type rsp_ff, rsp_in;

   logic sys_we, q_we, ws_we;
   logic [PW-1:0] tail;
   logic [HW:0] sys_sum, q_sum;
   logic [HW-1:0] sys_new, q_new;
   logic csr_we;
   logic [4:0] csr_val;

   assign csr_we = psel && penable && pwrite && (paddr[2] == dtqom_pkg::REG_QUEUE_LIMIT);
   assign csr_val = pwdata[4:0];
   assign prdata = (paddr[2] == dtqom_pkg::REG_QUEUE_LIMIT) ? dtqom_pkg::CSR_DW'(limit_ff) : '0;

   always_comb begin
      int tsum;
      tsum = 32'(head_ff) + 32'(count_ff);
      if (tsum >= QUEUE_DEPTH) begin
         tsum = tsum - QUEUE_DEPTH;
      end
      tail = PW'(tsum);
   end

   assign sys_sum = {1'b0, sys_rd_ff} + (HW + 1)'(sys_delta_ff);
   assign q_sum = {1'b0, q_rd_ff} + (HW + 1)'(q_delta_ff);
   assign sys_new = (sys_sum >= (HW + 1)'(dtqom_pkg::HIST_MAX)) ? dtqom_pkg::HIST_MAX
                                                               : sys_sum[HW-1:0];
   assign q_new = (q_sum >= (HW + 1)'(dtqom_pkg::HIST_MAX)) ? dtqom_pkg::HIST_MAX
                                                         : q_sum[HW-1:0];

   always_comb begin
      clr_in = clr_ff;
      head_in = head_ff;
      count_in = count_ff;
      srv_busy_in = srv_busy_ff;
      svc_id_in = svc_id_ff;
      sys_last_in = sys_last_ff;
      q_last_in = q_last_ff;
      limit_in = limit_ff;
      op_in = op_ff;
      pid_in = pid_ff;
      now_in = now_ff;
      sys_delta_in = sys_delta_ff;
      q_delta_in = q_delta_ff;
      sys_ok_in = sys_ok_ff;
      q_ok_in = q_ok_ff;
      sys_addr_in = sys_addr_ff;
      q_addr_in = q_addr_ff;
      sys_we = 1'b0;
      q_we = 1'b0;
      ws_we = 1'b0;
      rsp_in = rsp_ff;

      if (cmd.clear) begin
         clr_in = clr_ff + SYS_AW'(1);
      end

      if (csr_we) begin
         if (32'(csr_val) > QUEUE_DEPTH) begin
            limit_in = CW'(QUEUE_DEPTH);
         end else begin
            limit_in = CW'(csr_val);
         end
      end

      if (cmd.accept) begin
         op_in = req_word.op;
         pid_in = req_word.packet_id;
         now_in = req_word.now_time;
         sys_delta_in = (req_word.now_time >= sys_last_ff) ? req_word.now_time - sys_last_ff
                                                           : '0;
         q_delta_in = (req_word.now_time >= q_last_ff) ? req_word.now_time - q_last_ff : '0;
         sys_ok_in = 32'(req_word.bin_index) < SYS_DEPTH;
         q_ok_in = 32'(req_word.bin_index) < Q_DEPTH;
         if (req_word.op == dtqom_pkg::OP_READ) begin
            sys_addr_in = SYS_AW'(req_word.bin_index);
            q_addr_in = Q_AW'(req_word.bin_index);
         end else begin
            sys_addr_in = SYS_AW'(32'(count_ff) + 32'(srv_busy_ff));
            q_addr_in = Q_AW'(count_ff);
         end
      end

      if (cmd.exec) begin
         rsp_in = '0;
         case (op_ff)
            dtqom_pkg::OP_ARRIVAL: begin
               rsp_in.affected_packet = pid_ff;
               if (!srv_busy_ff) begin
                  sys_we = 1'b1;
                  sys_last_in = now_ff;
                  srv_busy_in = 1'b1;
                  svc_id_in = pid_ff;
                  rsp_in.action = dtqom_pkg::ACT_SERVED;
               end else if ((count_ff < limit_ff) && (32'(count_ff) < QUEUE_DEPTH)) begin
                  sys_we = 1'b1;
                  q_we = 1'b1;
                  ws_we = 1'b1;
                  sys_last_in = now_ff;
                  q_last_in = now_ff;
                  count_in = count_ff + CW'(1);
                  rsp_in.action = dtqom_pkg::ACT_QUEUED;
               end else begin
                  rsp_in.action = dtqom_pkg::ACT_DROPPED;
               end
            end
            dtqom_pkg::OP_DEPARTURE: begin
               rsp_in.error_flag = !srv_busy_ff;
               sys_we = 1'b1;
               sys_last_in = now_ff;
               if (count_ff != '0) begin
                  q_we = 1'b1;
                  q_last_in = now_ff;
                  srv_busy_in = 1'b1;
                  svc_id_in = ws_rd_ff;
                  head_in = (head_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PW'(1);
                  count_in = count_ff - CW'(1);
                  rsp_in.action = dtqom_pkg::ACT_STARTED;
                  rsp_in.affected_packet = ws_rd_ff;
               end else begin
                  srv_busy_in = 1'b0;
                  rsp_in.action = dtqom_pkg::ACT_IDLE;
               end
            end
            dtqom_pkg::OP_READ: begin
               rsp_in.action = dtqom_pkg::ACT_READ;
               rsp_in.error_flag = !sys_ok_ff;
               rsp_in.system_bin_time = sys_ok_ff ? sys_rd_ff : '0;
               rsp_in.queue_bin_time = q_ok_ff ? q_rd_ff : '0;
            end
            default: begin
               rsp_in.action = dtqom_pkg::ACT_READ;
               rsp_in.error_flag = 1'b1;
            end
         endcase
         rsp_in.occupancy = dtqom_pkg::LEVEL_W'(32'(count_in) + 32'(srv_busy_in));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         head_ff <= '0;
         count_ff <= '0;
         srv_busy_ff <= 1'b0;
         svc_id_ff <= '0;
         sys_last_ff <= '0;
         q_last_ff <= '0;
         limit_ff <= CW'(QUEUE_DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         head_ff <= head_in;
         count_ff <= count_in;
         srv_busy_ff <= srv_busy_in;
         svc_id_ff <= svc_id_in;
         sys_last_ff <= sys_last_in;
         q_last_ff <= q_last_in;
         limit_ff <= limit_in;
         rsp_valid_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      pid_ff <= pid_in;
      now_ff <= now_in;
      sys_delta_ff <= sys_delta_in;
      q_delta_ff <= q_delta_in;
      sys_ok_ff <= sys_ok_in;
      q_ok_ff <= q_ok_in;
      sys_addr_ff <= sys_addr_in;
      q_addr_ff <= q_addr_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         sys_mem[clr_ff] <= '0;
      end else if (sys_we) begin
         sys_mem[sys_addr_ff] <= sys_new;
      end
      sys_rd_ff <= sys_mem[sys_addr_in];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         if (32'(clr_ff) < Q_DEPTH) begin
            q_mem[Q_AW'(clr_ff)] <= '0;
         end
      end else if (q_we) begin
         q_mem[q_addr_ff] <= q_new;
      end
      q_rd_ff <= q_mem[q_addr_in];
   end

   always_ff @(posedge clock) begin
      if (ws_we) begin
         ws_mem[tail] <= pid_ff;
      end
      ws_rd_ff <= ws_mem[head_ff];
   end

   assign status.clear_last = (32'(clr_ff) == SYS_DEPTH - 1);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

endmodule

>>> rtl/core/droptail_queue_occupancy_monitor_core.sv
// Top level of the drop-tail queue occupancy monitor.
// Joins the controller and the datapath and drives the register port handshake.
// Depends on dtqom_pkg, dtqom_ctrl and dtqom_datapath.

// For each word, the accepting edge reads the histogram memories and the
// wait store, and the next cycle does the saturating add and the write-back.
// The result is registered at the end of that cycle and is on rsp_word for
// one cycle, marked by rsp_valid; busy is low again in that cycle, so a new
// word may start then, but not while a word is in progress. The receiver
// cannot stall. After reset a clearing pass zeroes the histograms with busy
// high; register writes are taken at any time.
module droptail_queue_occupancy_monitor_core #(
   parameter int QUEUE_DEPTH = dtqom_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  dtqom_pkg::req_word_type req_word,
   output logic rsp_valid,
   output dtqom_pkg::rsp_word_type rsp_word,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [dtqom_pkg::CSR_AW-1:0] paddr,
   input  logic [dtqom_pkg::CSR_DW-1:0] pwdata,
   output logic [dtqom_pkg::CSR_DW-1:0] prdata,
   output logic pready
);

   dtqom_pkg::cmd_type cmd;
   dtqom_pkg::status_type status;

   assign pready = 1'b1;

   dtqom_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .cmd(cmd),
      .status(status)
   );

   dtqom_datapath #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_word(rsp_word),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata)
   );

endmodule

>>> rtl/core/dtqom_checker.sv
// Port-level checker for the drop-tail queue occupancy monitor.
// Watches the top level's ports only and is bound to the top level below.
// Depends on dtqom_pkg.
module dtqom_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input dtqom_pkg::rsp_word_type rsp_word,
   input logic pready
);

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted word");

   a_accept_then_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("no result two cycles after an accepted word");

   a_result_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results in two consecutive cycles");

   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.action <= dtqom_pkg::ACT_READ))
      else $error("result carries an undefined action");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready dropped");

endmodule

bind droptail_queue_occupancy_monitor_core dtqom_checker u_dtqom_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_word(rsp_word),
   .pready(pready)
);
